// ===== hdl/bpms_pkg.sv =====
// Shared types and constants for the bus poll master scheduler.
package bpms_pkg;

   localparam int DEF_MAX_CHANNELS = 64;

   localparam logic [15:0] DEFAULT_TIMEOUT     = 16'd100;
   localparam logic [16:0] RESET_REQUEST_TIMER = 17'd5;

   localparam logic       RESET_MASTER_ENABLE = 1'b0;
   localparam logic [6:0] RESET_CHANNEL_COUNT = 7'd0;
   localparam logic [7:0] RESET_REQUEST_PAUSE = 8'd2;
   localparam logic [2:0] RESET_ERROR_LIMIT   = 3'd5;

   localparam int CSR_IDX_W  = 2;
   localparam int CSR_DATA_W = 8;

   typedef enum logic [CSR_IDX_W-1:0] {
      CSR_MASTER_ENABLE = 2'd0,
      CSR_CHANNEL_COUNT = 2'd1,
      CSR_REQUEST_PAUSE = 2'd2,
      CSR_ERROR_LIMIT   = 2'd3
   } csr_idx_type;

   typedef enum logic [1:0] {
      ST_PENDING = 2'd0,
      ST_OK      = 2'd1,
      ST_TIMEOUT = 2'd2
   } status_type;

   typedef enum logic {
      FUNC_POLL  = 1'b0,
      FUNC_WRITE = 1'b1
   } func_type;

   typedef struct packed {
      logic       master_enable;
      logic [6:0] channel_count;
      logic [7:0] request_pause;
      logic [2:0] error_limit;
   } cfg_type;

   typedef struct packed {
      logic        func;
      logic        tick;
      logic        response_ok;
      logic [5:0]  entry_channel;
      logic [15:0] entry_timeout;
      logic        entry_present;
   } req_type;

   typedef struct packed {
      logic [5:0] active_channel;
      logic       request_sent;
      logic       restore_uart;
      logic       set_timeout_error;
      logic       clear_timeout_error;
      status_type channel_status;
      logic       round_wrapped;
   } rsp_type;

   typedef struct packed {
      logic [15:0] timeout;
      logic        present;
   } chan_cfg_type;

   typedef struct packed {
      status_type status;
      logic [2:0] err_count;
   } chan_st_type;

   localparam chan_cfg_type CHAN_CFG_RESET = '{timeout: DEFAULT_TIMEOUT, present: 1'b0};
   localparam chan_st_type  CHAN_ST_RESET  = '{status: ST_PENDING, err_count: 3'd0};

endpackage

// ===== hdl/bpms_if.sv =====
// Channel interfaces: poll/table request, step result and register write.
interface bpms_req_if;
   logic        valid;
   logic        ready;
   logic        func;
   logic        tick;
   logic        response_ok;
   logic [5:0]  entry_channel;
   logic [15:0] entry_timeout;
   logic        entry_present;

   modport source (output valid, func, tick, response_ok, entry_channel, entry_timeout,
                   entry_present, input ready);
   modport sink (input valid, func, tick, response_ok, entry_channel, entry_timeout,
                 entry_present, output ready);
endinterface

interface bpms_rsp_if;
   logic       valid;
   logic       ready;
   logic [5:0] active_channel;
   logic       request_sent;
   logic       restore_uart;
   logic       set_timeout_error;
   logic       clear_timeout_error;
   logic [1:0] channel_status;
   logic       round_wrapped;

   modport source (output valid, active_channel, request_sent, restore_uart,
                   set_timeout_error, clear_timeout_error, channel_status, round_wrapped,
                   input ready);
   modport sink (input valid, active_channel, request_sent, restore_uart,
                 set_timeout_error, clear_timeout_error, channel_status, round_wrapped,
                 output ready);
endinterface

interface bpms_csr_if;
   logic       valid;
   logic       ready;
   logic [1:0] index;
   logic [7:0] data;

   modport source (output valid, index, data, input ready);
   modport sink (input valid, index, data, output ready);
endinterface

// ===== hdl/bpms_csr.sv =====
// Configuration registers written through the register write channel.
module bpms_csr
   import bpms_pkg::*;
(
   input  logic            clock,
   input  logic            reset,
   bpms_csr_if.sink        csr_ch,
   output cfg_type         cfg
);

   cfg_type cfg_ff;

   assign csr_ch.ready = 1'b1;
   assign cfg          = cfg_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_ff.master_enable <= RESET_MASTER_ENABLE;
         cfg_ff.channel_count <= RESET_CHANNEL_COUNT;
         cfg_ff.request_pause <= RESET_REQUEST_PAUSE;
         cfg_ff.error_limit   <= RESET_ERROR_LIMIT;
      end else if (csr_ch.valid) begin
         case (csr_idx_type'(csr_ch.index))
            CSR_MASTER_ENABLE: begin
               cfg_ff.master_enable <= csr_ch.data[0];
            end
            CSR_CHANNEL_COUNT: begin
               cfg_ff.channel_count <= csr_ch.data[6:0];
            end
            CSR_REQUEST_PAUSE: begin
               cfg_ff.request_pause <= csr_ch.data;
            end
            CSR_ERROR_LIMIT: begin
               cfg_ff.error_limit <= csr_ch.data[2:0];
            end
            default: begin
               cfg_ff <= cfg_ff;
            end
         endcase
      end
   end

endmodule

// ===== hdl/bpms_tables.sv =====
// Per-channel tables with valid bits and a registered read of the next slot.
module bpms_tables
   import bpms_pkg::*;
#(
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
)
(
   input  logic               clock,
   input  logic               reset,
   input  logic [IDX_W-1:0]   rd_addr,
   input  logic               cfg_we,
   input  logic [IDX_W-1:0]   cfg_addr,
   input  chan_cfg_type       cfg_wdata,
   input  logic               st_we,
   input  logic [IDX_W-1:0]   st_addr,
   input  chan_st_type        st_wdata,
   output chan_cfg_type       rd_cfg,
   output chan_st_type        rd_st
);

   chan_cfg_type            cfg_mem [MAX_CHANNELS];
   chan_st_type             st_mem  [MAX_CHANNELS];
   logic [MAX_CHANNELS-1:0] cfg_vld_ff;
   logic [MAX_CHANNELS-1:0] st_vld_ff;

   chan_cfg_type cfg_q_ff;
   chan_cfg_type cfg_byp_data_ff;
   logic         cfg_q_vld_ff;
   logic         cfg_byp_ff;
   chan_st_type  st_q_ff;
   chan_st_type  st_byp_data_ff;
   logic         st_q_vld_ff;
   logic         st_byp_ff;

   always_ff @(posedge clock) begin
      if (cfg_we) begin
         cfg_mem[cfg_addr] <= cfg_wdata;
      end
      if (st_we) begin
         st_mem[st_addr] <= st_wdata;
      end
      cfg_q_ff        <= cfg_mem[rd_addr];
      st_q_ff         <= st_mem[rd_addr];
      cfg_byp_data_ff <= cfg_wdata;
      st_byp_data_ff  <= st_wdata;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cfg_vld_ff   <= '0;
         st_vld_ff    <= '0;
         cfg_q_vld_ff <= 1'b0;
         st_q_vld_ff  <= 1'b0;
         cfg_byp_ff   <= 1'b0;
         st_byp_ff    <= 1'b0;
      end else begin
         if (cfg_we) begin
            cfg_vld_ff[cfg_addr] <= 1'b1;
         end
         if (st_we) begin
            st_vld_ff[st_addr] <= 1'b1;
         end
         cfg_q_vld_ff <= cfg_vld_ff[rd_addr];
         st_q_vld_ff  <= st_vld_ff[rd_addr];
         cfg_byp_ff   <= cfg_we && (cfg_addr == rd_addr);
         st_byp_ff    <= st_we && (st_addr == rd_addr);
      end
   end

   assign rd_cfg = cfg_byp_ff ? cfg_byp_data_ff : (cfg_q_vld_ff ? cfg_q_ff : CHAN_CFG_RESET);
   assign rd_st  = st_byp_ff ? st_byp_data_ff : (st_q_vld_ff ? st_q_ff : CHAN_ST_RESET);

endmodule

// ===== hdl/bpms_sched.sv =====
// Poll step logic: timers, round-robin slot advance and reply/timeout handling.
module bpms_sched
   import bpms_pkg::*;
#(
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS,
   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1
)
(
   input  logic               clock,
   input  logic               reset,
   input  cfg_type            cfg,
   input  logic               acc,
   input  req_type            req,
   input  chan_cfg_type       pf_cfg,
   input  chan_st_type        pf_st,
   output logic [IDX_W-1:0]   rd_addr,
   output logic               cfg_we,
   output logic [IDX_W-1:0]   cfg_addr,
   output chan_cfg_type       cfg_wdata,
   output logic               st_we,
   output logic [IDX_W-1:0]   st_addr,
   output chan_st_type        st_wdata,
   output rsp_type            rsp
);

   localparam int CNT_W = $clog2(MAX_CHANNELS + 1);
   localparam int CMP_W = (CNT_W > 7) ? CNT_W : 7;
   localparam int OUT_W = (IDX_W > 6) ? IDX_W : 6;

   logic [IDX_W-1:0] cur_slot_ff, cur_slot_in;
   logic [IDX_W-1:0] next_slot_ff, next_slot_in;
   logic [16:0]      rq_ff, rq_in;
   logic [15:0]      rx_ff, rx_in;
   logic             cur_present_ff, cur_present_in;
   status_type       cur_status_ff, cur_status_in;
   logic [2:0]       cur_err_ff, cur_err_in;

   logic [CMP_W-1:0] count_ext, count_eff, next_inc, ent_ext;
   logic [OUT_W-1:0] slot_out;
   logic             poll_go, tbl_wr, ent_ok, adv, pres, wrapped;
   logic             req_sent, restore, set_err, clr_err;
   logic [16:0]      rq_dec;
   logic [15:0]      rx_dec;
   logic [IDX_W-1:0] slot, next_calc;
   status_type       st_sel, st_new;
   logic [2:0]       err_sel, err_new;

   always_comb begin
      count_ext = CMP_W'(cfg.channel_count);
      count_eff = (count_ext > CMP_W'(MAX_CHANNELS)) ? CMP_W'(MAX_CHANNELS) : count_ext;
      ent_ext   = CMP_W'(req.entry_channel);
      ent_ok    = ent_ext < CMP_W'(MAX_CHANNELS);
      tbl_wr    = acc && (func_type'(req.func) == FUNC_WRITE);
      poll_go   = acc && (func_type'(req.func) == FUNC_POLL) && cfg.master_enable
                  && (count_eff != '0);

      rq_dec = rq_ff;
      if (req.tick && (rq_ff != '0)) begin
         rq_dec = rq_ff - 17'd1;
      end
      rx_dec = rx_ff;
      if (req.tick && (rx_ff != '0)) begin
         rx_dec = rx_ff - 16'd1;
      end

      adv       = (rq_dec == '0);
      next_inc  = CMP_W'(next_slot_ff) + CMP_W'(1);
      wrapped   = adv && (next_inc >= count_eff);
      next_calc = wrapped ? '0 : next_inc[IDX_W-1:0];

      slot    = adv ? next_slot_ff : cur_slot_ff;
      pres    = adv ? pf_cfg.present : cur_present_ff;
      st_sel  = adv ? pf_st.status : cur_status_ff;
      err_sel = adv ? pf_st.err_count : cur_err_ff;

      req_sent = adv && pres;
      rx_in    = req_sent ? pf_cfg.timeout : rx_dec;
      rq_in    = req_sent ? (17'(pf_cfg.timeout) + 17'(cfg.request_pause)) : rq_dec;
      st_new   = req_sent ? ST_PENDING : st_sel;
      err_new  = err_sel;
      restore  = 1'b0;
      set_err  = 1'b0;
      clr_err  = 1'b0;

      if (pres) begin
         if (rx_in != '0) begin
            if (req.response_ok) begin
               clr_err = 1'b1;
               err_new = 3'd0;
               st_new  = ST_OK;
               rx_in   = '0;
            end
         end else begin
            restore = 1'b1;
            if (st_new == ST_PENDING) begin
               st_new = ST_TIMEOUT;
               if (err_sel < cfg.error_limit) begin
                  err_new = err_sel + 3'd1;
               end else begin
                  set_err = 1'b1;
               end
            end
         end
      end

      cur_slot_in    = cur_slot_ff;
      next_slot_in   = next_slot_ff;
      cur_present_in = cur_present_ff;
      cur_status_in  = cur_status_ff;
      cur_err_in     = cur_err_ff;
      if (poll_go) begin
         cur_slot_in    = slot;
         next_slot_in   = adv ? next_calc : next_slot_ff;
         cur_present_in = pres;
         cur_status_in  = st_new;
         cur_err_in     = err_new;
      end else if (tbl_wr && ent_ok && (ent_ext[IDX_W-1:0] == cur_slot_ff)) begin
         cur_present_in = req.entry_present;
      end

      rd_addr   = next_slot_in;
      cfg_we    = tbl_wr && ent_ok;
      cfg_addr  = ent_ext[IDX_W-1:0];
      cfg_wdata = '{timeout: req.entry_timeout, present: req.entry_present};
      st_we     = poll_go && pres;
      st_addr   = slot;
      st_wdata  = '{status: st_new, err_count: err_new};

      slot_out                = OUT_W'(cur_slot_in);
      rsp.active_channel      = slot_out[5:0];
      rsp.request_sent        = poll_go && req_sent;
      rsp.restore_uart        = poll_go && restore;
      rsp.set_timeout_error   = poll_go && set_err;
      rsp.clear_timeout_error = poll_go && clr_err;
      rsp.channel_status      = cur_status_in;
      rsp.round_wrapped       = poll_go && wrapped;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         cur_slot_ff    <= '0;
         next_slot_ff   <= '0;
         rq_ff          <= RESET_REQUEST_TIMER;
         rx_ff          <= '0;
         cur_present_ff <= 1'b0;
         cur_status_ff  <= ST_PENDING;
         cur_err_ff     <= 3'd0;
      end else begin
         cur_slot_ff    <= cur_slot_in;
         next_slot_ff   <= next_slot_in;
         cur_present_ff <= cur_present_in;
         cur_status_ff  <= cur_status_in;
         cur_err_ff     <= cur_err_in;
         if (poll_go) begin
            rq_ff <= rq_in;
            rx_ff <= rx_in;
         end
      end
   end

   a_next_slot_range: assert property (@(posedge clock) disable iff (reset)
      CNT_W'(next_slot_ff) < CNT_W'(MAX_CHANNELS))
      else $error("next slot beyond channel table");

   a_set_err_on_timeout: assert property (@(posedge clock) disable iff (reset)
      acc && rsp.set_timeout_error |-> rsp.restore_uart && rsp.channel_status == ST_TIMEOUT)
      else $error("timeout error without closed window");

   a_table_write_holds_timers: assert property (@(posedge clock) disable iff (reset)
      tbl_wr |=> $stable(rq_ff) && $stable(rx_ff) && $stable(cur_slot_ff))
      else $error("table write disturbed poll state");

   a_clear_resets_count: assert property (@(posedge clock) disable iff (reset)
      acc && rsp.clear_timeout_error |=> cur_err_ff == 3'd0 && cur_status_ff == ST_OK)
      else $error("good reply did not clear error count");

endmodule

// ===== hdl/bpms_out_buf.sv =====
// Result register with a skid stage in front of the result channel.
module bpms_out_buf
   import bpms_pkg::*;
(
   input  logic       clock,
   input  logic       reset,
   input  logic       push,
   input  rsp_type    push_data,
   output logic       push_ready,
   bpms_rsp_if.source rsp_ch
);

   rsp_type out_ff, skid_ff;
   logic    out_vld_ff, skid_vld_ff;
   logic    pop;

   assign push_ready = !skid_vld_ff;
   assign pop        = out_vld_ff && rsp_ch.ready;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_vld_ff  <= 1'b0;
         skid_vld_ff <= 1'b0;
      end else if (pop && skid_vld_ff) begin
         skid_vld_ff <= 1'b0;
      end else if (pop || !out_vld_ff) begin
         out_vld_ff <= push;
      end else if (push) begin
         skid_vld_ff <= 1'b1;
      end
   end

   always_ff @(posedge clock) begin
      if (pop && skid_vld_ff) begin
         out_ff <= skid_ff;
      end else if (pop || !out_vld_ff) begin
         out_ff <= push_data;
      end else if (push) begin
         skid_ff <= push_data;
      end
   end

   assign rsp_ch.valid               = out_vld_ff;
   assign rsp_ch.active_channel      = out_ff.active_channel;
   assign rsp_ch.request_sent        = out_ff.request_sent;
   assign rsp_ch.restore_uart        = out_ff.restore_uart;
   assign rsp_ch.set_timeout_error   = out_ff.set_timeout_error;
   assign rsp_ch.clear_timeout_error = out_ff.clear_timeout_error;
   assign rsp_ch.channel_status      = out_ff.channel_status;
   assign rsp_ch.round_wrapped       = out_ff.round_wrapped;

endmodule

// ===== hdl/bus_poll_master_scheduler.sv =====
// Round-robin bus poll master scheduler, top level.
//
// req_ch carries one step per transfer: a poll step (func 0) with its tick and
// reply flags, or a table write (func 1) that loads one channel's timeout and
// presence. Every accepted step gives exactly one result on rsp_ch: the active
// channel, request/restore/error flags, its status and a round-wrap flag.
// csr_ch writes the four setup registers (enable, channel count, pause, error
// limit); it is always ready and should be used while no step is in flight.
// An accepted step's result is registered in the output register, or in the skid stage while the receiver stalls.
// Throughput: one step per cycle while the skid stage is empty; the step logic reads the next slot's table
// entry from a registered prefetch, so no wait states are added.
// A result waits in the output register while the receiver stalls; one more
// step is held in the skid stage, then req_ch.ready drops until a transfer
// drains the output.
// Reset: setup registers return to their defaults, all channels read as absent
// with a timeout of 100 ticks, request timer 5, slot counters zero. No clearing
// pass is needed; steps are taken from the first cycle after reset.
module bus_poll_master_scheduler
   import bpms_pkg::*;
#(
   parameter int MAX_CHANNELS = DEF_MAX_CHANNELS
)
(
   input  logic       clock,
   input  logic       reset,
   bpms_req_if.sink   req_ch,
   bpms_rsp_if.source rsp_ch,
   bpms_csr_if.sink   csr_ch
);

   localparam int IDX_W = (MAX_CHANNELS > 1) ? $clog2(MAX_CHANNELS) : 1;

   cfg_type          cfg;
   req_type          req;
   rsp_type          rsp;
   chan_cfg_type     pf_cfg, cfg_wdata;
   chan_st_type      pf_st, st_wdata;
   logic [IDX_W-1:0] rd_addr, cfg_addr, st_addr;
   logic             cfg_we, st_we, acc, push_ready;

   assign req_ch.ready = push_ready;
   assign acc          = req_ch.valid && push_ready;

   assign req.func          = req_ch.func;
   assign req.tick          = req_ch.tick;
   assign req.response_ok   = req_ch.response_ok;
   assign req.entry_channel = req_ch.entry_channel;
   assign req.entry_timeout = req_ch.entry_timeout;
   assign req.entry_present = req_ch.entry_present;

   bpms_csr u_csr (
      .clock  (clock),
      .reset  (reset),
      .csr_ch (csr_ch),
      .cfg    (cfg)
   );

   bpms_tables #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_tables (
      .clock     (clock),
      .reset     (reset),
      .rd_addr   (rd_addr),
      .cfg_we    (cfg_we),
      .cfg_addr  (cfg_addr),
      .cfg_wdata (cfg_wdata),
      .st_we     (st_we),
      .st_addr   (st_addr),
      .st_wdata  (st_wdata),
      .rd_cfg    (pf_cfg),
      .rd_st     (pf_st)
   );

   bpms_sched #(
      .MAX_CHANNELS (MAX_CHANNELS)
   ) u_sched (
      .clock     (clock),
      .reset     (reset),
      .cfg       (cfg),
      .acc       (acc),
      .req       (req),
      .pf_cfg    (pf_cfg),
      .pf_st     (pf_st),
      .rd_addr   (rd_addr),
      .cfg_we    (cfg_we),
      .cfg_addr  (cfg_addr),
      .cfg_wdata (cfg_wdata),
      .st_we     (st_we),
      .st_addr   (st_addr),
      .st_wdata  (st_wdata),
      .rsp       (rsp)
   );

   bpms_out_buf u_out_buf (
      .clock      (clock),
      .reset      (reset),
      .push       (acc),
      .push_data  (rsp),
      .push_ready (push_ready),
      .rsp_ch     (rsp_ch)
   );

endmodule
